/* src/mva_pkg.sv */
// Shared types, codes and constants for the Mobius vector adder.
// No dependencies; every other file imports this package.
package mva_pkg;

	localparam int MaxDim = 64;
	localparam int AddrW  = 6;
	localparam int CntW   = 7;

	typedef logic signed [23:0] elem_t;
	typedef logic [23:0]        curv_t;
	typedef logic [1:0]         status_t;
	typedef logic [3:0]         mop_t;

	localparam curv_t CurvReset = 24'd65536;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_OVF = 2'd1;
	localparam status_t ST_DEN = 2'd2;

	// multiplier operations; the code travels with the product one stage
	localparam mop_t MOP_NONE = 4'd0;
	localparam mop_t MOP_XY   = 4'd1;
	localparam mop_t MOP_XX   = 4'd2;
	localparam mop_t MOP_YY   = 4'd3;
	localparam mop_t MOP_CD   = 4'd4;
	localparam mop_t MOP_CX   = 4'd5;
	localparam mop_t MOP_CY   = 4'd6;
	localparam mop_t MOP_MHH  = 4'd7;
	localparam mop_t MOP_MHL  = 4'd8;
	localparam mop_t MOP_MLH  = 4'd9;
	localparam mop_t MOP_MLL  = 4'd10;
	localparam mop_t MOP_AHX  = 4'd11;
	localparam mop_t MOP_BHY  = 4'd12;
	localparam mop_t MOP_ALX  = 4'd13;
	localparam mop_t MOP_BLY  = 4'd14;

	typedef struct packed {
		logic    load;
		mop_t    mop;
		logic    m_clr;
		logic    den_ld;
		logic    div_start;
		logic    div_sel_b;
		logic    latch_a;
		logic    latch_b;
		logic    n_ld;
		logic    st_ld;
		status_t st_val;
		logic    idx_clr;
		logic    idx_inc;
		logic    rd;
		logic    s_clr;
		logic    emit;
		logic    emit_zero;
		logic    clr_vec;
	} mva_cmd_t;

	typedef struct packed {
		logic full;
		logic ovf;
		logic den_nonpos;
		logic div_done;
		logic out_free;
		logic idx_last;
	} mva_sts_t;

endpackage

/* src/mva_cfg_if.sv */
// Curvature write channel.
// Depends on mva_pkg.
interface mva_cfg_if import mva_pkg::*; ();
	logic  valid;
	logic  ready;
	curv_t curvature;

	modport source (output valid, output curvature, input ready);
	modport sink (input valid, input curvature, output ready);
endinterface

/* src/mva_item_if.sv */
// Input element channel.
// Depends on mva_pkg.
interface mva_item_if import mva_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  command;
	elem_t x_elem;
	elem_t y_elem;
	logic  last_elem;

	modport source (output valid, output command, output x_elem, output y_elem,
		output last_elem, input ready);
	modport sink (input valid, input command, input x_elem, input y_elem,
		input last_elem, output ready);
endinterface

/* src/mva_res_if.sv */
// Result element channel.
// Depends on mva_pkg.
interface mva_res_if import mva_pkg::*; ();
	logic    valid;
	logic    ready;
	elem_t   out_elem;
	logic    last_out;
	status_t status;

	modport source (output valid, output out_elem, output last_out, output status,
		input ready);
	modport sink (input valid, input out_elem, input last_out, input status,
		output ready);
endinterface

/* src/mva_div.sv */
// Restoring divider, one quotient bit per cycle: trunc(num * 2^20 / den),
// clamped to +-2^38. Depends on mva_pkg.
module mva_div import mva_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [43:0] num,
	input  logic [62:0]        den,
	output logic               done,
	output logic signed [39:0] quo
);

	localparam logic [62:0] CoefLim = 63'd1 << 38;

	logic        busy_q, done_q, neg_q;
	logic [5:0]  cnt_q;
	logic [62:0] rem_q, q_q, den_q;
	logic [43:0] mag;
	logic [63:0] trial;
	logic        ge;
	logic [39:0] qmag;

	assign mag   = num[43] ? 44'(-num) : 44'(num);
	assign trial = {rem_q, q_q[62]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd62;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= {mag[42:0], 20'd0};
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[43];
		end else if (busy_q) begin
			rem_q <= ge ? 63'(trial - {1'b0, den_q}) : trial[62:0];
			q_q   <= {q_q[61:0], ge};
		end
	end

	assign qmag = (q_q > CoefLim) ? 40'(CoefLim) : {1'b0, q_q[38:0]};
	assign quo  = neg_q ? -$signed(qmag) : $signed(qmag);
	assign done = done_q;

endmodule

/* src/mva_dp.sv */
// Datapath: element store, shared multiplier, sums, coefficient terms,
// divider and result register. Depends on mva_pkg and mva_div.
module mva_dp import mva_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  curv_t    cfg_data,
	input  logic     item_cmd,
	input  elem_t    item_x,
	input  elem_t    item_y,
	input  mva_cmd_t cmd,
	output mva_sts_t sts,
	output logic     res_valid,
	input  logic     res_ready,
	output elem_t    res_elem,
	output logic     res_last,
	output status_t  res_status
);

	localparam logic signed [47:0] SumMax = 48'sd8388607;
	localparam logic signed [47:0] SumMin = -48'sd8388608;

	curv_t curv_q;
	elem_t x_q, y_q;
	logic  neg_q;

	logic [47:0] mem [MaxDim];
	logic [47:0] rdata_q;

	logic [CntW-1:0] cnt_q, n_q, idx_q;
	logic            ovf_q;
	logic signed [55:0] dot_q;
	logic [55:0]        xn_q, yn_q;

	logic signed [34:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [60:0] mul_p, prod_s1;
	mop_t               mop_s1;

	logic signed [41:0] cd_q;
	logic [40:0]        cx_q, cy_q;
	logic [63:0]        m_q;
	logic signed [63:0] den_q, den_c;
	logic signed [43:0] num_a, num_b;
	logic signed [39:0] a_q, b_q, div_quo;
	logic               div_done;
	logic signed [47:0] s_hi_q, s_lo_q, s_tot;
	status_t            st_q;

	logic               res_valid_q, res_last_q;
	elem_t              res_elem_q;
	status_t            res_status_q;
	elem_t              sat;

	elem_t              rx, ry;
	logic signed [24:0] xe;
	logic signed [56:0] dext, dsel;
	logic               full;

	assign full = cnt_q == CntW'(MaxDim);
	assign rx   = rdata_q[47:24];
	assign ry   = rdata_q[23:0];
	assign xe   = neg_q ? -{rx[23], rx} : {rx[23], rx};
	assign dext = {dot_q[55], dot_q};
	assign dsel = neg_q ? -dext : dext;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mop)
			MOP_XY: begin
				mul_a = {{11{x_q[23]}}, x_q};
				mul_b = {{2{y_q[23]}}, y_q};
			end
			MOP_XX: begin
				mul_a = {{11{x_q[23]}}, x_q};
				mul_b = {{2{x_q[23]}}, x_q};
			end
			MOP_YY: begin
				mul_a = {{11{y_q[23]}}, y_q};
				mul_b = {{2{y_q[23]}}, y_q};
			end
			MOP_CD: begin
				mul_a = dsel[54:20];
				mul_b = {2'b0, curv_q};
			end
			MOP_CX: begin
				mul_a = xn_q[54:20];
				mul_b = {2'b0, curv_q};
			end
			MOP_CY: begin
				mul_a = yn_q[54:20];
				mul_b = {2'b0, curv_q};
			end
			MOP_MHH: begin
				mul_a = {14'd0, cx_q[40:20]};
				mul_b = {6'd0, cy_q[40:21]};
			end
			MOP_MHL: begin
				mul_a = {14'd0, cx_q[40:20]};
				mul_b = {5'd0, cy_q[20:0]};
			end
			MOP_MLH: begin
				mul_a = {15'd0, cx_q[19:0]};
				mul_b = {6'd0, cy_q[40:21]};
			end
			MOP_MLL: begin
				mul_a = {15'd0, cx_q[19:0]};
				mul_b = {5'd0, cy_q[20:0]};
			end
			MOP_AHX: begin
				mul_a = {{15{a_q[39]}}, a_q[39:20]};
				mul_b = {xe[24], xe};
			end
			MOP_BHY: begin
				mul_a = {{15{b_q[39]}}, b_q[39:20]};
				mul_b = {{2{ry[23]}}, ry};
			end
			MOP_ALX: begin
				mul_a = {15'd0, a_q[19:0]};
				mul_b = {xe[24], xe};
			end
			MOP_BLY: begin
				mul_a = {15'd0, b_q[19:0]};
				mul_b = {{2{ry[23]}}, ry};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign num_a = 44'sd1048576 + {cd_q[41], cd_q, 1'b0} + {3'd0, cy_q};
	assign num_b = 44'sd1048576 - {3'd0, cx_q};
	assign den_c = 64'sd1048576 + {{21{cd_q[41]}}, cd_q, 1'b0} + $signed(m_q);

	mva_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel_b ? num_b : num_a),
		.den    (den_q[62:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[cnt_q[AddrW-1:0]] <= {item_x, item_y};
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q[AddrW-1:0]];
		end
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curv_q      <= CurvReset;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			dot_q       <= '0;
			xn_q        <= '0;
			yn_q        <= '0;
			mop_s1      <= MOP_NONE;
			idx_q       <= '0;
			n_q         <= '0;
			st_q        <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) curv_q <= cfg_data;
			mop_s1 <= cmd.mop;
			if (cmd.clr_vec) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				dot_q <= '0;
				xn_q  <= '0;
				yn_q  <= '0;
			end else begin
				if (cmd.load) begin
					if (full) ovf_q <= 1'b1;
					else cnt_q <= cnt_q + 1'b1;
				end
				case (mop_s1)
					MOP_XY: dot_q <= dot_q + prod_s1[55:0];
					MOP_XX: xn_q <= xn_q + prod_s1[55:0];
					MOP_YY: yn_q <= yn_q + prod_s1[55:0];
					default: ;
				endcase
			end
			if (cmd.n_ld) n_q <= ovf_q ? CntW'(MaxDim) : cnt_q;
			if (cmd.st_ld) st_q <= cmd.st_val;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;
		if (cmd.load) begin
			x_q   <= item_x;
			y_q   <= item_y;
			neg_q <= item_cmd;
		end
		if (cmd.m_clr) m_q <= '0;
		if (cmd.s_clr) begin
			s_hi_q <= '0;
			s_lo_q <= '0;
		end
		case (mop_s1)
			MOP_CD:  cd_q <= prod_s1[57:16];
			MOP_CX:  cx_q <= prod_s1[56:16];
			MOP_CY:  cy_q <= prod_s1[56:16];
			MOP_MHH: m_q <= m_q + ({22'd0, prod_s1[41:0]} << 21);
			MOP_MHL: m_q <= m_q + {22'd0, prod_s1[41:0]};
			MOP_MLH: m_q <= m_q + ({22'd0, prod_s1[41:0]} << 1);
			MOP_MLL: m_q <= m_q + {43'd0, prod_s1[40:20]};
			MOP_AHX, MOP_BHY: s_hi_q <= s_hi_q + prod_s1[47:0];
			MOP_ALX, MOP_BLY: s_lo_q <= s_lo_q + prod_s1[47:0];
			default: ;
		endcase
		if (cmd.den_ld) den_q <= den_c;
		if (cmd.latch_a) a_q <= div_quo;
		if (cmd.latch_b) b_q <= div_quo;
		if (cmd.emit) begin
			res_elem_q   <= cmd.emit_zero ? '0 : sat;
			res_last_q   <= sts.idx_last;
			res_status_q <= st_q;
		end
	end

	assign s_tot = s_hi_q + (s_lo_q >>> 20);
	assign sat   = (s_tot > SumMax) ? 24'sh7fffff :
		(s_tot < SumMin) ? 24'sh800000 : s_tot[23:0];

	assign sts.full       = full;
	assign sts.ovf        = ovf_q;
	assign sts.den_nonpos = den_q[63] || (den_q == 64'sd0);
	assign sts.div_done   = div_done;
	assign sts.out_free   = !res_valid_q || res_ready;
	assign sts.idx_last   = idx_q == (n_q - 1'b1);

	assign res_valid  = res_valid_q;
	assign res_elem   = res_elem_q;
	assign res_last   = res_last_q;
	assign res_status = res_status_q;

endmodule

/* src/mva_ctrl.sv */
// Sequencer for load, coefficient and emit phases.
// Depends on mva_pkg; drives mva_dp through command and status structs.
module mva_ctrl import mva_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     item_last,
	output logic     item_ready,
	input  mva_sts_t sts,
	output mva_cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_MXY  = 5'd1;
	localparam logic [4:0] S_MXX  = 5'd2;
	localparam logic [4:0] S_MYY  = 5'd3;
	localparam logic [4:0] S_CHK  = 5'd4;
	localparam logic [4:0] S_CD   = 5'd5;
	localparam logic [4:0] S_CX   = 5'd6;
	localparam logic [4:0] S_CY   = 5'd7;
	localparam logic [4:0] S_W1   = 5'd8;
	localparam logic [4:0] S_M0   = 5'd9;
	localparam logic [4:0] S_M1   = 5'd10;
	localparam logic [4:0] S_M2   = 5'd11;
	localparam logic [4:0] S_M3   = 5'd12;
	localparam logic [4:0] S_W2   = 5'd13;
	localparam logic [4:0] S_DEN  = 5'd14;
	localparam logic [4:0] S_DCHK = 5'd15;
	localparam logic [4:0] S_DIVA = 5'd16;
	localparam logic [4:0] S_DIVB = 5'd17;
	localparam logic [4:0] S_RD   = 5'd18;
	localparam logic [4:0] S_O0   = 5'd19;
	localparam logic [4:0] S_O1   = 5'd20;
	localparam logic [4:0] S_O2   = 5'd21;
	localparam logic [4:0] S_O3   = 5'd22;
	localparam logic [4:0] S_OW   = 5'd23;
	localparam logic [4:0] S_EMIT = 5'd24;
	localparam logic [4:0] S_ZERO = 5'd25;

	logic [4:0] state_q, state_d;
	logic       last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		last_d     = last_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					last_d   = item_last;
					if (!sts.full) state_d = S_MXY;
					else if (item_last) state_d = S_CHK;
				end
			end
			S_MXY: begin
				cmd.mop = MOP_XY;
				state_d = S_MXX;
			end
			S_MXX: begin
				cmd.mop = MOP_XX;
				state_d = S_MYY;
			end
			S_MYY: begin
				cmd.mop = MOP_YY;
				state_d = last_q ? S_CHK : S_IDLE;
			end
			S_CHK: begin
				cmd.n_ld    = 1'b1;
				cmd.idx_clr = 1'b1;
				cmd.st_ld   = 1'b1;
				cmd.st_val  = sts.ovf ? ST_OVF : ST_OK;
				state_d     = sts.ovf ? S_ZERO : S_CD;
			end
			S_CD: begin
				cmd.mop   = MOP_CD;
				cmd.m_clr = 1'b1;
				state_d   = S_CX;
			end
			S_CX: begin
				cmd.mop = MOP_CX;
				state_d = S_CY;
			end
			S_CY: begin
				cmd.mop = MOP_CY;
				state_d = S_W1;
			end
			S_W1: state_d = S_M0;
			S_M0: begin
				cmd.mop = MOP_MHH;
				state_d = S_M1;
			end
			S_M1: begin
				cmd.mop = MOP_MHL;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.mop = MOP_MLH;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.mop = MOP_MLL;
				state_d = S_W2;
			end
			S_W2: state_d = S_DEN;
			S_DEN: begin
				cmd.den_ld = 1'b1;
				state_d    = S_DCHK;
			end
			S_DCHK: begin
				if (sts.den_nonpos) begin
					cmd.st_ld  = 1'b1;
					cmd.st_val = ST_DEN;
					state_d    = S_ZERO;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVA;
				end
			end
			S_DIVA: begin
				if (sts.div_done) begin
					cmd.latch_a   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_b = 1'b1;
					state_d       = S_DIVB;
				end
			end
			S_DIVB: begin
				if (sts.div_done) begin
					cmd.latch_b = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RD: begin
				cmd.rd    = 1'b1;
				cmd.s_clr = 1'b1;
				state_d   = S_O0;
			end
			S_O0: begin
				cmd.mop = MOP_AHX;
				state_d = S_O1;
			end
			S_O1: begin
				cmd.mop = MOP_BHY;
				state_d = S_O2;
			end
			S_O2: begin
				cmd.mop = MOP_ALX;
				state_d = S_O3;
			end
			S_O3: begin
				cmd.mop = MOP_BLY;
				state_d = S_OW;
			end
			S_OW: state_d = S_EMIT;
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.idx_inc = 1'b1;
					if (sts.idx_last) begin
						cmd.clr_vec = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_ZERO: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_zero = 1'b1;
					cmd.idx_inc   = 1'b1;
					if (sts.idx_last) begin
						cmd.clr_vec = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* src/mobius_vector_add.sv */
// Top level of the Mobius vector adder: joins the channels to the
// sequencer (mva_ctrl) and the datapath (mva_dp). Depends on mva_pkg
// and the three channel interfaces.
//
//  channel  dir  payload                                handshake
//  cfg      in   curvature (u Q8.16)                    valid/ready, ready held high
//  item     in   command, x_elem, y_elem, last_elem     valid/ready
//  result   out  out_elem, last_out, status             valid/ready
//
// Each stored element pair is accepted, then x*y, x*x, y*y are formed on the one
// shared multiplier. After the last pair, the denominator terms are formed
// and two 63-step divisions give the coefficients. Each result then takes
// a store read plus four partial products; flagged vectors give one zero
// per cycle while the result channel is ready.
// Reset clears sums, counters and handshake state; the element store is
// not cleared. A stalled result stalls the emit loop; items are not
// taken while a vector is being finished.
module mobius_vector_add import mva_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	mva_cfg_if.sink    cfg,
	mva_item_if.sink   item,
	mva_res_if.source  result
);

	mva_cmd_t cmd;
	mva_sts_t sts;

	// curvature is to be written between vectors only, which the block does not enforce; always ready
	assign cfg.ready = 1'b1;

	mva_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_last  (item.last_elem),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mva_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.curvature),
		.item_cmd   (item.command),
		.item_x     (item.x_elem),
		.item_y     (item.y_elem),
		.cmd        (cmd),
		.sts        (sts),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_elem   (result.out_elem),
		.res_last   (result.last_out),
		.res_status (result.status)
	);

endmodule
